// ===== hw/rtl/smerl_pkg.sv =====
// shared types and constants for the sensor median / ema / slew limiter
// used by every module of the block; no dependencies
package smerl_pkg;

   localparam int DATA_W     = 12;
   localparam int LEVEL_W    = 15;
   localparam int DT_W       = 16;
   localparam int TAU_W      = 16;
   localparam int SLEW_W     = 15;
   localparam int MUL_W      = 16;
   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int BIT_W      = 4;

   localparam logic [LEVEL_W-1:0]   FULL_SCALE = 15'd25600;
   localparam logic [DIV_DEN_W-1:0] MS_PER_S   = 17'd1000;

   // reciprocal of 1000 scaled by 2^41, exact for numerators below 2^31
   localparam int                   RECIP_SHIFT = 41;
   localparam logic [DIV_NUM_W-1:0] RECIP_MS    = 32'd2199023256;

   localparam logic [DATA_W-1:0]  EMPTY_RESET = 12'd300;
   localparam logic [DATA_W-1:0]  FULL_RESET  = 12'd3800;
   localparam logic [TAU_W-1:0]   TAU_RESET   = 16'd3000;
   localparam logic [SLEW_W-1:0]  SLEW_RESET  = 15'd1280;

   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAU   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEL_INIT, ST_SCAN, ST_BIT, ST_SEL_NEXT, ST_MEDIAN, ST_TARGET,
      ST_PCT_DIV, ST_PCT_WAIT, ST_EMA, ST_EMA_DIV, ST_EMA_WAIT, ST_SLEW,
      ST_SLEW_DIV, ST_SLEW_WAIT, ST_RESULT
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_PUSH, CMD_LOAD, CMD_SEL_INIT, CMD_SCAN, CMD_SEL_BIT,
      CMD_SEL_NEXT, CMD_MEDIAN, CMD_TGT_CLAMP, CMD_PCT_MUL, CMD_PCT_DIV,
      CMD_PCT_LOAD, CMD_EMA_SEED, CMD_EMA_MUL, CMD_EMA_DIV, CMD_EMA_LOAD,
      CMD_SHOW_SEED, CMD_SLEW_MUL, CMD_SLEW_DIV, CMD_SLEW_LOAD, CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic seen_ready;
      logic scan_done;
      logic last_bit;
      logic need_second;
      logic median_clamp;
      logic div_done;
      logic sm_valid;
      logic sh_valid;
      logic dt_zero;
      logic slot_free;
   } status_type;

endpackage

// ===== hw/rtl/smerl_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on smerl_pkg
module smerl_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [smerl_pkg::DIV_NUM_W-1:0]   num,
   input  logic [smerl_pkg::DIV_DEN_W-1:0]   den,
   output logic                              done,
   output logic [smerl_pkg::DIV_NUM_W-1:0]   quot
);
   import smerl_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NUM_W);
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_DEN_W'(shifted - {1'b0, den_ff}) : shifted[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ===== hw/rtl/smerl_dp.sv =====
// datapath: window memory, rank selection, calibration map, ema, slew, result register
// depends on smerl_pkg and smerl_div
module smerl_dp #(
   parameter int WINDOW_LEN = 64,
   parameter int MIN_READY  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  smerl_pkg::cmd_type                 cmd,
   output smerl_pkg::status_type              status,
   input  logic [smerl_pkg::DATA_W-1:0]       req_sample,
   input  logic [smerl_pkg::DT_W-1:0]         req_dt_ms,
   input  logic                               csr_valid,
   input  logic [smerl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [smerl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [smerl_pkg::LEVEL_W-1:0]      rsp_level,
   output logic                               rsp_ready_res
);
   import smerl_pkg::*;

   localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int RCP_W = 2 * DIV_NUM_W;
   localparam int LIM_W = RCP_W - RECIP_SHIFT;

   logic [DATA_W-1:0]  mem [WINDOW_LEN];

   logic [DATA_W-1:0]  empty_ff, empty_in, full_ff, full_in;
   logic [TAU_W-1:0]   tau_ff, tau_in;
   logic [SLEW_W-1:0]  slew_ff, slew_in;
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic [DT_W-1:0]    dt_ff, dt_in;
   logic               res_ok_ff, res_ok_in;
   logic [DATA_W-1:0]  sel_p_ff, sel_p_in, sel_a_ff, sel_a_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CNT_W-1:0]   rank_ff, rank_in, addr_ff, addr_in, cnt_ff, cnt_in;
   logic               rd_vld_ff, rd_vld_in, second_ff, second_in;
   logic [DATA_W-1:0]  rd_data_ff;
   logic [DATA_W-1:0]  med_ff, med_in;
   logic [LEVEL_W-1:0] target_ff, target_in, smooth_ff, smooth_in, shown_ff, shown_in;
   logic               dir_ff, dir_in, sm_valid_ff, sm_valid_in, sh_valid_ff, sh_valid_in;
   logic [DIV_NUM_W-1:0] prod_ff, prod_in;
   logic [RCP_W-1:0]   recip_ff, recip_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_ready_ff, rsp_ready_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;

   logic               rd_en, push, seen_ready, tgt_ge, sh_le;
   logic [DATA_W-1:0]  mask_lo, thresh, bit_one;
   logic [CNT_W-1:0]   half;
   logic [LEVEL_W-1:0] ediff, sdiff, sstep;
   logic [LIM_W-1:0]   slew_lim;
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic               div_start, div_done;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] quot;

   always_comb begin
      seen_ready = 32'(seen_ff) >= 32'(MIN_READY);
      half       = seen_ff >> 1;
      mask_lo    = DATA_W'((13'd1 << bit_ff) - 13'd1);
      thresh     = sel_p_ff | mask_lo;
      bit_one    = DATA_W'(1) << bit_ff;
      push       = (cmd == CMD_PUSH);
      rd_en      = (cmd == CMD_SCAN) && (addr_ff < seen_ff);
      tgt_ge     = target_ff >= smooth_ff;
      ediff      = tgt_ge ? target_ff - smooth_ff : smooth_ff - target_ff;
      sh_le      = smooth_ff >= shown_ff;
      sdiff      = sh_le ? smooth_ff - shown_ff : shown_ff - smooth_ff;
      slew_lim   = recip_ff[RCP_W-1:RECIP_SHIFT];
      sstep      = ({{(LIM_W-LEVEL_W){1'b0}}, sdiff} > slew_lim) ?
                   slew_lim[LEVEL_W-1:0] : sdiff;
   end

   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_den   = MS_PER_S;
      unique case (cmd)
         CMD_PCT_MUL: begin
            mul_a = MUL_W'(med_ff - empty_ff);
            mul_b = MUL_W'(FULL_SCALE);
         end
         CMD_EMA_MUL: begin
            mul_a = MUL_W'(ediff);
            mul_b = dt_ff;
         end
         CMD_SLEW_MUL: begin
            mul_a = MUL_W'(slew_ff);
            mul_b = dt_ff;
         end
         CMD_PCT_DIV: begin
            div_start = 1'b1;
            div_den   = DIV_DEN_W'(full_ff - empty_ff);
         end
         CMD_EMA_DIV: begin
            div_start = 1'b1;
            div_den   = DIV_DEN_W'(tau_ff) + DIV_DEN_W'(dt_ff);
         end
         default: ;
      endcase
   end

   smerl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      empty_in     = empty_ff;
      full_in      = full_ff;
      tau_in       = tau_ff;
      slew_in      = slew_ff;
      wptr_in      = wptr_ff;
      seen_in      = seen_ff;
      dt_in        = dt_ff;
      res_ok_in    = res_ok_ff;
      sel_p_in     = sel_p_ff;
      sel_a_in     = sel_a_ff;
      bit_in       = bit_ff;
      rank_in      = rank_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = rd_en;
      second_in    = second_ff;
      med_in       = med_ff;
      target_in    = target_ff;
      smooth_in    = smooth_ff;
      shown_in     = shown_ff;
      dir_in       = dir_ff;
      sm_valid_in  = sm_valid_ff;
      sh_valid_in  = sh_valid_ff;
      prod_in      = DIV_NUM_W'(mul_a * mul_b);
      recip_in     = recip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_level_in = rsp_level_ff;
      rsp_ready_in = rsp_ready_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_EMPTY: empty_in = csr_wdata[DATA_W-1:0];
            CSR_FULL:  full_in  = csr_wdata[DATA_W-1:0];
            CSR_TAU:   tau_in   = csr_wdata[TAU_W-1:0];
            CSR_SLEW:  slew_in  = csr_wdata[SLEW_W-1:0];
            default: ;
         endcase
      end

      if (rd_vld_ff && (rd_data_ff <= thresh)) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (rd_en) begin
         addr_in = addr_ff + CNT_W'(1);
      end

      unique case (cmd)
         CMD_PUSH: begin
            wptr_in = (wptr_ff == PTR_W'(WINDOW_LEN - 1)) ? '0 : wptr_ff + PTR_W'(1);
            if (seen_ff != CNT_W'(WINDOW_LEN)) begin
               seen_in = seen_ff + CNT_W'(1);
            end
         end
         CMD_LOAD: begin
            dt_in     = req_dt_ms;
            res_ok_in = seen_ready;
         end
         CMD_SEL_INIT: begin
            sel_p_in  = '0;
            bit_in    = BIT_W'(DATA_W - 1);
            rank_in   = seen_ff[0] ? half : half - CNT_W'(1);
            second_in = 1'b0;
            addr_in   = '0;
            cnt_in    = '0;
         end
         CMD_SEL_BIT: begin
            if (cnt_ff <= rank_ff) begin
               sel_p_in = sel_p_ff | bit_one;
            end
            bit_in  = bit_ff - BIT_W'(1);
            addr_in = '0;
            cnt_in  = '0;
         end
         CMD_SEL_NEXT: begin
            sel_a_in  = sel_p_ff;
            sel_p_in  = '0;
            bit_in    = BIT_W'(DATA_W - 1);
            rank_in   = half;
            second_in = 1'b1;
            addr_in   = '0;
            cnt_in    = '0;
         end
         CMD_MEDIAN: begin
            med_in = seen_ff[0] ? sel_p_ff
                   : DATA_W'(({1'b0, sel_a_ff} + {1'b0, sel_p_ff}) >> 1);
         end
         CMD_TGT_CLAMP: target_in = (med_ff <= empty_ff) ? '0 : FULL_SCALE;
         CMD_PCT_LOAD:  target_in = quot[LEVEL_W-1:0];
         CMD_EMA_SEED: begin
            smooth_in   = target_ff;
            sm_valid_in = 1'b1;
         end
         CMD_EMA_MUL: dir_in = tgt_ge;
         CMD_EMA_LOAD: begin
            smooth_in = dir_ff ? smooth_ff + quot[LEVEL_W-1:0]
                               : smooth_ff - quot[LEVEL_W-1:0];
         end
         CMD_SHOW_SEED: begin
            shown_in    = smooth_ff;
            sh_valid_in = 1'b1;
         end
         CMD_SLEW_DIV:  recip_in = RCP_W'(prod_ff) * RCP_W'(RECIP_MS);
         CMD_SLEW_LOAD: shown_in = sh_le ? shown_ff + sstep : shown_ff - sstep;
         CMD_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_level_in = res_ok_ff ? shown_ff : '0;
            rsp_ready_in = res_ok_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= req_sample;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr_ff[PTR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff     <= EMPTY_RESET;
         full_ff      <= FULL_RESET;
         tau_ff       <= TAU_RESET;
         slew_ff      <= SLEW_RESET;
         wptr_ff      <= '0;
         seen_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         smooth_ff    <= '0;
         shown_ff     <= '0;
         sm_valid_ff  <= 1'b0;
         sh_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         empty_ff     <= empty_in;
         full_ff      <= full_in;
         tau_ff       <= tau_in;
         slew_ff      <= slew_in;
         wptr_ff      <= wptr_in;
         seen_ff      <= seen_in;
         rd_vld_ff    <= rd_vld_in;
         smooth_ff    <= smooth_in;
         shown_ff     <= shown_in;
         sm_valid_ff  <= sm_valid_in;
         sh_valid_ff  <= sh_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff        <= dt_in;
      res_ok_ff    <= res_ok_in;
      sel_p_ff     <= sel_p_in;
      sel_a_ff     <= sel_a_in;
      bit_ff       <= bit_in;
      rank_ff      <= rank_in;
      addr_ff      <= addr_in;
      cnt_ff       <= cnt_in;
      second_ff    <= second_in;
      med_ff       <= med_in;
      target_ff    <= target_in;
      dir_ff       <= dir_in;
      prod_ff      <= prod_in;
      recip_ff     <= recip_in;
      rsp_level_ff <= rsp_level_in;
      rsp_ready_ff <= rsp_ready_in;
   end

   always_comb begin
      status.seen_ready   = seen_ready;
      status.scan_done    = (addr_ff == seen_ff) && !rd_vld_ff;
      status.last_bit     = (bit_ff == '0);
      status.need_second  = !seen_ff[0] && !second_ff;
      status.median_clamp = (med_ff <= empty_ff) || (med_ff >= full_ff);
      status.div_done     = div_done;
      status.sm_valid     = sm_valid_ff;
      status.sh_valid     = sh_valid_ff;
      status.dt_zero      = (dt_ff == '0);
      status.slot_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_ready_res = rsp_ready_ff;

endmodule

// ===== hw/rtl/smerl_ctrl.sv =====
// controller state machine sequencing median search, calibration, ema and slew
// depends on smerl_pkg
module smerl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_stall,
   input  smerl_pkg::status_type   status,
   output smerl_pkg::cmd_type      cmd
);
   import smerl_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_op) begin
               state_in = status.seen_ready ? ST_SEL_INIT : ST_RESULT;
            end
         end
         ST_SEL_INIT: state_in = ST_SCAN;
         ST_SCAN:     if (status.scan_done) state_in = ST_BIT;
         ST_BIT: begin
            if (status.last_bit) begin
               state_in = status.need_second ? ST_SEL_NEXT : ST_MEDIAN;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SEL_NEXT: state_in = ST_SCAN;
         ST_MEDIAN:   state_in = ST_TARGET;
         ST_TARGET:   state_in = status.median_clamp ? ST_EMA : ST_PCT_DIV;
         ST_PCT_DIV:  state_in = ST_PCT_WAIT;
         ST_PCT_WAIT: if (status.div_done) state_in = ST_EMA;
         ST_EMA: begin
            if (!status.sm_valid || status.dt_zero) begin
               state_in = ST_SLEW;
            end else begin
               state_in = ST_EMA_DIV;
            end
         end
         ST_EMA_DIV:  state_in = ST_EMA_WAIT;
         ST_EMA_WAIT: if (status.div_done) state_in = ST_SLEW;
         ST_SLEW:     state_in = status.sh_valid ? ST_SLEW_DIV : ST_RESULT;
         ST_SLEW_DIV: state_in = ST_SLEW_WAIT;
         ST_SLEW_WAIT: state_in = ST_RESULT;
         ST_RESULT:   if (status.slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:      if (req_valid) cmd = req_op ? CMD_LOAD : CMD_PUSH;
         ST_SEL_INIT:  cmd = CMD_SEL_INIT;
         ST_SCAN:      cmd = CMD_SCAN;
         ST_BIT:       cmd = CMD_SEL_BIT;
         ST_SEL_NEXT:  cmd = CMD_SEL_NEXT;
         ST_MEDIAN:    cmd = CMD_MEDIAN;
         ST_TARGET:    cmd = status.median_clamp ? CMD_TGT_CLAMP : CMD_PCT_MUL;
         ST_PCT_DIV:   cmd = CMD_PCT_DIV;
         ST_PCT_WAIT:  if (status.div_done) cmd = CMD_PCT_LOAD;
         ST_EMA: begin
            if (!status.sm_valid) begin
               cmd = CMD_EMA_SEED;
            end else if (!status.dt_zero) begin
               cmd = CMD_EMA_MUL;
            end
         end
         ST_EMA_DIV:   cmd = CMD_EMA_DIV;
         ST_EMA_WAIT:  if (status.div_done) cmd = CMD_EMA_LOAD;
         ST_SLEW:      cmd = status.sh_valid ? CMD_SLEW_MUL : CMD_SHOW_SEED;
         ST_SLEW_DIV:  cmd = CMD_SLEW_DIV;
         ST_SLEW_WAIT: cmd = CMD_SLEW_LOAD;
         ST_RESULT:    if (status.slot_free) cmd = CMD_OUT;
         default:      cmd = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_PCT_WAIT || state_ff == ST_EMA_WAIT))
      else $error("divider finished outside a wait state");
   a_result_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && status.slot_free) |=> state_ff == ST_IDLE)
      else $error("result state did not return to idle");
   a_scan_to_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_done) |=> state_ff == ST_BIT)
      else $error("finished scan did not move to bit decision");
`endif

endmodule

// ===== hw/rtl/sensor_median_ema_rate_limiter.sv =====
// Sensor median / ema / slew limiter, top level.
// Input channel req_*: op 0 pushes a 12-bit sample into the window ring and gives no
// result; op 1 requests an update and gives exactly one transfer on rsp_*.
// A transfer happens on a rising edge with valid high and stall low.
// Config channel csr_*: index 0 empty count, 1 full count, 2 tau ms, 3 slew per second;
// csr_ready is always high, write only while the block is idle.
// An update with too few samples goes straight to the result state and gives level 0,
// ready_res 0. A full update finds the median by a bitwise rank search: twelve scans
// of the filled window (n entries, one memory read per cycle) per middle value, one
// middle value for odd n and two for even n, then up to two divisions (percent map,
// ema) on one shared divider and a reciprocal multiply for the slew limit.
// One item is worked on at a time.
// Reset clears pointers, counts, filter state and config registers to their defaults; the
// window memory itself is not cleared. A stalled result waits in the output register
// while further samples are still taken.
// Depends on smerl_pkg, smerl_ctrl, smerl_dp, smerl_div.
module sensor_median_ema_rate_limiter #(
   parameter int WINDOW_LEN = 64,
   parameter int MIN_READY  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [smerl_pkg::DATA_W-1:0]       req_sample,
   input  logic [smerl_pkg::DT_W-1:0]         req_dt_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [smerl_pkg::LEVEL_W-1:0]      rsp_level,
   output logic                               rsp_ready_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [smerl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [smerl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import smerl_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   smerl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smerl_dp #(
      .WINDOW_LEN (WINDOW_LEN),
      .MIN_READY  (MIN_READY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample    (req_sample),
      .req_dt_ms     (req_dt_ms),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_level     (rsp_level),
      .rsp_ready_res (rsp_ready_res)
   );

endmodule
